### src/obb_pkg.sv
// Shared types and constants for the oriented-box face-axis overlap test.
package obb_pkg;

    localparam int CompW   = 32;
    localparam int AxisW   = 16;
    localparam int HalfW   = 31;
    localparam int NumRows = 6;
    localparam int RowW    = $clog2(NumRows);

    localparam logic [1:0] KIND_CENTRE = 2'd0;
    localparam logic [1:0] KIND_AXIS   = 2'd1;
    localparam logic [1:0] KIND_TEST   = 2'd2;
    localparam logic [2:0] NO_SEPARATION = 3'd6;
    localparam logic [2:0] LAST_FACE_AXIS = 3'd5;

    typedef struct packed {
        logic [1:0]              kind;
        logic                    box_select;
        logic [1:0]              axis_index;
        logic signed [CompW-1:0] comp_x;
        logic signed [CompW-1:0] comp_y;
        logic signed [CompW-1:0] comp_z;
        logic [HalfW-1:0]        half_length;
    } in_item_t;

    typedef struct packed {
        logic       overlap;
        logic [2:0] separating_axis;
    } out_item_t;

    typedef enum logic [1:0] {
        CMD_CENTRE = 2'd0,
        CMD_AXIS   = 2'd1,
        CMD_TEST   = 2'd2
    } cmd_t;

    typedef struct packed {
        cmd_t     cmd;
        in_item_t item;
    } q_entry_t;

    typedef struct packed {
        logic     valid;
        q_entry_t entry;
    } q_head_t;

endpackage

### src/obb_front.sv
// Front end: accept beats, classify them and hold them in a two-entry queue.
module obb_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  obb_pkg::in_item_t item,
    output logic              busy,
    output obb_pkg::q_head_t  head,
    input  logic              pop
);
    import obb_pkg::*;

    q_entry_t   mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       keep;
    logic       push;
    cmd_t       cmd;

    // Classify: drop unknown kinds and axis loads past the third axis.
    always_comb
    begin
        keep = 1'b0;
        cmd  = CMD_TEST;
        unique case (item.kind)
            KIND_CENTRE:
            begin
                keep = 1'b1;
                cmd  = CMD_CENTRE;
            end
            KIND_AXIS:
            begin
                keep = (item.axis_index != 2'd3);
                cmd  = CMD_AXIS;
            end
            KIND_TEST:
            begin
                keep = 1'b1;
                cmd  = CMD_TEST;
            end
            default:
            begin
                keep = 1'b0;
                cmd  = CMD_TEST;
            end
        endcase
    end

    assign busy = (count_reg == 2'd2);
    assign push = start && !busy && keep;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= '{cmd: cmd, item: item};
        end
    end

    assign head.valid = (count_reg != 2'd0);
    assign head.entry = mem_reg[rd_ptr_reg];

endmodule

### src/obb_back.sv
// Back end: box stores and the shared-multiplier sequencer for the axis tests.
module obb_back (
    input  logic               clk,
    input  logic               rst_n,
    input  obb_pkg::q_head_t   head,
    output logic               pop,
    output logic               result_valid,
    output obb_pkg::out_item_t result
);
    import obb_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_LOADN = 5'b00010,
        S_MUL   = 5'b00100,
        S_ACC   = 5'b01000,
        S_CHECK = 5'b10000
    } state_t;

    state_t                  state_reg, state_next;
    logic signed [CompW-1:0] centre_reg [2][3];
    logic [3*AxisW-1:0]      axis_reg [NumRows];
    logic [HalfW-1:0]        ext_reg [NumRows];

    logic signed [CompW:0]   off_reg [3];
    logic signed [AxisW-1:0] n_reg [3];
    logic [HalfW+13:0]       rown_reg;
    logic signed [51:0]      dist_reg;
    logic signed [34:0]      d_reg;
    logic [53:0]             r_reg;
    logic signed [65:0]      prod_reg;
    logic [2:0]              k_reg;
    logic [1:0]              seg_reg;
    logic [1:0]              c_reg;
    logic                    rv_reg;
    out_item_t               res_reg;

    logic                    own;
    logic [1:0]              own_idx;
    logic [1:0]              other_j;
    logic [RowW-1:0]         row;
    logic [3*AxisW-1:0]      rd_axis;
    logic [HalfW-1:0]        rd_ext;
    logic signed [AxisW-1:0] m_c;
    logic signed [33:0]      op_a;
    logic signed [31:0]      op_b;
    logic [33:0]             d_mag;
    logic [51:0]             dist_mag;
    logic [54:0]             bound;
    logic                    separates;

    assign own     = (k_reg > 3'd2);
    assign own_idx = own ? 2'(k_reg - 3'd3) : k_reg[1:0];
    assign other_j = seg_reg - 2'd1;

    // One row read port: own axis while loading, other box's axes otherwise.
    always_comb
    begin
        if (state_reg == S_LOADN)
        begin
            row = own ? 3'd3 + {1'b0, own_idx} : {1'b0, own_idx};
        end
        else
        begin
            row = own ? {1'b0, other_j} : 3'd3 + {1'b0, other_j};
        end
    end

    assign rd_axis = axis_reg[row];
    assign rd_ext  = ext_reg[row];

    always_comb
    begin
        case (c_reg)
            2'd0:    m_c = rd_axis[AxisW-1:0];
            2'd1:    m_c = rd_axis[2*AxisW-1:AxisW];
            default: m_c = rd_axis[3*AxisW-1:2*AxisW];
        endcase
    end

    assign d_mag = d_reg[34] ? 34'(-d_reg) : d_reg[33:0];

    // Operand select for the shared multiplier.
    always_comb
    begin
        op_a = '0;
        op_b = '0;
        if (seg_reg == 2'd0)
        begin
            op_a = 34'(off_reg[c_reg]);
            op_b = 32'(n_reg[c_reg]);
        end
        else if (c_reg == 2'd3)
        begin
            op_a = {14'd0, d_mag[33:14]};
            op_b = {1'b0, rd_ext};
        end
        else
        begin
            op_a = 34'(n_reg[c_reg]);
            op_b = 32'(m_c);
        end
    end

    assign dist_mag  = dist_reg[51] ? 52'(-dist_reg) : 52'(dist_reg);
    assign bound     = 55'(rown_reg) + 55'(r_reg);
    assign separates = ({3'd0, dist_mag} > bound);

    assign pop = head.valid && (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (pop && head.entry.cmd == CMD_TEST)
                begin
                    state_next = S_LOADN;
                end
            end
            S_LOADN: state_next = S_MUL;
            S_MUL:   state_next = S_ACC;
            S_ACC:
            begin
                if (seg_reg == 2'd3 && c_reg == 2'd3)
                begin
                    state_next = S_CHECK;
                end
                else
                begin
                    state_next = S_MUL;
                end
            end
            S_CHECK:
            begin
                if (separates || k_reg == LAST_FACE_AXIS)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_LOADN;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            rv_reg    <= 1'b0;
            k_reg     <= 3'd0;
            seg_reg   <= 2'd0;
            c_reg     <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            rv_reg    <= (state_reg == S_CHECK) && (separates || k_reg == LAST_FACE_AXIS);
            if (state_reg == S_IDLE)
            begin
                k_reg <= 3'd0;
            end
            else if (state_reg == S_CHECK)
            begin
                k_reg <= k_reg + 3'd1;
            end
            if (state_reg == S_LOADN)
            begin
                seg_reg <= 2'd0;
                c_reg   <= 2'd0;
            end
            else if (state_reg == S_ACC)
            begin
                if (seg_reg == 2'd0 && c_reg == 2'd2)
                begin
                    seg_reg <= 2'd1;
                    c_reg   <= 2'd0;
                end
                else if (c_reg == 2'd3)
                begin
                    seg_reg <= seg_reg + 2'd1;
                    c_reg   <= 2'd0;
                end
                else
                begin
                    c_reg <= c_reg + 2'd1;
                end
            end
        end
    end

    // Stores and datapath.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            unique case (head.entry.cmd)
                CMD_CENTRE:
                begin
                    centre_reg[head.entry.item.box_select][0] <= head.entry.item.comp_x;
                    centre_reg[head.entry.item.box_select][1] <= head.entry.item.comp_y;
                    centre_reg[head.entry.item.box_select][2] <= head.entry.item.comp_z;
                end
                CMD_AXIS:
                begin
                    axis_reg[head.entry.item.box_select ? 3'd3 + {1'b0,
                        head.entry.item.axis_index} : {1'b0, head.entry.item.axis_index}]
                        <= {head.entry.item.comp_z[AxisW-1:0],
                            head.entry.item.comp_y[AxisW-1:0],
                            head.entry.item.comp_x[AxisW-1:0]};
                    ext_reg[head.entry.item.box_select ? 3'd3 + {1'b0,
                        head.entry.item.axis_index} : {1'b0, head.entry.item.axis_index}]
                        <= head.entry.item.half_length;
                end
                CMD_TEST:
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        off_reg[i] <= 33'(centre_reg[0][i]) - 33'(centre_reg[1][i]);
                    end
                end
                default:
                begin
                end
            endcase
        end
        if (state_reg == S_LOADN)
        begin
            n_reg[0] <= rd_axis[AxisW-1:0];
            n_reg[1] <= rd_axis[2*AxisW-1:AxisW];
            n_reg[2] <= rd_axis[3*AxisW-1:2*AxisW];
            rown_reg <= {rd_ext, 14'd0};
            dist_reg <= '0;
            d_reg    <= '0;
            r_reg    <= '0;
        end
        if (state_reg == S_MUL)
        begin
            prod_reg <= op_a * op_b;
        end
        if (state_reg == S_ACC)
        begin
            if (seg_reg == 2'd0)
            begin
                dist_reg <= dist_reg + prod_reg[51:0];
            end
            else if (c_reg == 2'd3)
            begin
                r_reg <= r_reg + prod_reg[53:0];
                d_reg <= '0;
            end
            else
            begin
                d_reg <= d_reg + prod_reg[34:0];
            end
        end
        if (state_reg == S_CHECK)
        begin
            res_reg.overlap         <= !separates;
            res_reg.separating_axis <= separates ? k_reg : NO_SEPARATION;
        end
    end

    assign result_valid = rv_reg;
    assign result       = res_reg;

endmodule

### src/obb_face_axis_overlap_test.sv
// Top level of the oriented-box face-axis overlap test.
// Usage:
//   Input channel: drive item and raise start; a beat is taken at a rising
//   edge where start is high and busy is low. Kind 0 loads a box centre
//   (Q16.16), kind 1 loads one unit axis (Q2.14, low 16 bits) with its half
//   length, kind 2 runs the test. Kind 3 and axis index 3 are dropped.
//   Beats pass through a two-entry queue; busy is high while it is full.
//   Loads retire as soon as they reach the queue head and the back end is idle.
//   A test runs on one shared 34x32 multiplier, each multiply issued and then
//   accumulated: per face axis one row fetch, 15 multiplies and one
//   compare. All six face axes are checked when none separates; the test
//   ends at the first axis that separates. The queue head is taken only
//   while the back end is idle, so a test finishes before the next beat
//   leaves the queue.
//   Output channel: one result beat per test on result, marked by a
//   one-cycle result_valid strobe; the receiver cannot stall, so results
//   never back up. Loads produce no beat.
//   Reset clears the queue and the sequencer; box stores are undefined
//   until loaded.
module obb_face_axis_overlap_test (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  obb_pkg::in_item_t  item,
    output logic               result_valid,
    output obb_pkg::out_item_t result
);
    import obb_pkg::*;

    q_head_t head;
    logic    pop;

    // Accept and classify beats, hold them until the back end is free.
    obb_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .item  (item),
        .busy  (busy),
        .head  (head),
        .pop   (pop)
    );

    // Execute loads and run the axis tests.
    obb_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .pop          (pop),
        .result_valid (result_valid),
        .result       (result)
    );

    // Overlap flag and axis code must agree.
    a_result_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.overlap == (result.separating_axis == NO_SEPARATION)))
        else $error("overlap flag disagrees with axis code");

    // A test spans many cycles, so strobes never come back to back.
    a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("result strobe held for two cycles");

    // Axis code stays in range.
    a_axis_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.separating_axis <= NO_SEPARATION))
        else $error("separating axis out of range");

endmodule

### test/tb_top.sv
// Testbench for the oriented-box face-axis overlap test: random and directed beats.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import obb_pkg::*;

    // Kind code that the block must drop without effect.
    localparam logic [1:0] KIND_DROPPED = 2'd3;
    localparam int AxisSlot3 = 3;
    localparam int NumRandom = 1520;
    localparam int StallLimit = 4000;
    localparam int DrainCycles = 400;

    logic      clk;
    logic      rst_n;
    logic      start;
    logic      busy;
    in_item_t  item;
    logic      result_valid;
    out_item_t result;

    obb_face_axis_overlap_test u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .result_valid (result_valid),
        .result       (result)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // Shadow copy of the box stores, kept in wide integers.
    longint    centre_q[6];
    longint    axis_q[18];
    longint    extent_q[6];

    in_item_t  pending_beats[$];
    out_item_t verdicts_due[$];
    int        error_count;
    int        beats_taken;
    int        total_beats;
    int        quiet_cycles;
    bit        taken_last_edge;

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        error_count++;
    endtask

    // Radius of box 'other' projected on a Q2.14 axis, in Q.30.
    function automatic longint projected_radius(input longint ax[3], input int other);
        longint sum;
        longint d;
        sum = 0;
        for (int j = 0; j < 3; j++)
        begin
            d = ax[0] * axis_q[other*9 + j*3] + ax[1] * axis_q[other*9 + j*3 + 1]
                + ax[2] * axis_q[other*9 + j*3 + 2];
            if (d < 0)
                d = -d;
            sum += (d >>> 14) * extent_q[other*3 + j];
        end
        return sum;
    endfunction

    // Walk the six face axes in order and name the first that separates.
    function automatic out_item_t overlap_verdict();
        out_item_t v;
        longint    off[3];
        longint    ax[3];
        longint    proj_dist;
        int        own;
        int        idx;
        v.overlap = 1'b1;
        v.separating_axis = NO_SEPARATION;
        for (int c = 0; c < 3; c++)
            off[c] = centre_q[c] - centre_q[3 + c];
        for (int k = 0; k < 6; k++)
        begin
            own = k / 3;
            idx = k % 3;
            for (int c = 0; c < 3; c++)
                ax[c] = axis_q[own*9 + idx*3 + c];
            proj_dist = off[0] * ax[0] + off[1] * ax[1] + off[2] * ax[2];
            if (proj_dist < 0)
                proj_dist = -proj_dist;
            if (proj_dist > (extent_q[own*3 + idx] << 14) + projected_radius(ax, 1 - own))
            begin
                v.overlap = 1'b0;
                v.separating_axis = 3'(k);
                return v;
            end
        end
        return v;
    endfunction

    // Apply one accepted beat to the shadow stores; queue a verdict for tests.
    task automatic absorb_beat(input in_item_t b);
        int bx;
        bx = b.box_select;
        case (b.kind)
            KIND_CENTRE:
            begin
                centre_q[bx*3]     = longint'(b.comp_x);
                centre_q[bx*3 + 1] = longint'(b.comp_y);
                centre_q[bx*3 + 2] = longint'(b.comp_z);
            end
            KIND_AXIS:
            begin
                if (b.axis_index != AxisSlot3)
                begin
                    axis_q[bx*9 + b.axis_index*3]     = longint'($signed(b.comp_x[15:0]));
                    axis_q[bx*9 + b.axis_index*3 + 1] = longint'($signed(b.comp_y[15:0]));
                    axis_q[bx*9 + b.axis_index*3 + 2] = longint'($signed(b.comp_z[15:0]));
                    extent_q[bx*3 + b.axis_index] = longint'(b.half_length);
                end
            end
            KIND_TEST:
                verdicts_due.push_back(overlap_verdict());
            default:
                ;
        endcase
    endtask

    function automatic in_item_t make_beat(input logic [1:0] k, input int bx, input int ai,
                                           input int x, input int y, input int z,
                                           input logic [30:0] h);
        in_item_t b;
        b.kind = k;
        b.box_select = 1'(bx);
        b.axis_index = 2'(ai);
        b.comp_x = x;
        b.comp_y = y;
        b.comp_z = z;
        b.half_length = h;
        return b;
    endfunction

    function automatic int rand_axis_comp();
        return int'($urandom_range(32768)) - 16384;
    endfunction

    function automatic int rand_centre_comp();
        return int'($urandom_range(20 * 65536)) - 10 * 65536;
    endfunction

    // Fully random beat over every field value.
    function automatic in_item_t noise_beat();
        return make_beat(2'($urandom), $urandom_range(1), $urandom_range(3), $urandom,
                         $urandom, $urandom, 31'($urandom));
    endfunction

    // Sample at the rising edge: accepted inputs feed the predictor,
    // result strobes are checked against the oldest verdict.
    always @(posedge clk)
    begin
        taken_last_edge = 1'b0;
        if (rst_n)
        begin
            quiet_cycles++;
            if (start && !busy)
            begin
                absorb_beat(item);
                beats_taken++;
                taken_last_edge = 1'b1;
                quiet_cycles = 0;
            end
            if (result_valid)
            begin
                quiet_cycles = 0;
                if (verdicts_due.size() == 0)
                    report_mismatch("result beat with no test outstanding");
                else
                begin
                    out_item_t want;
                    want = verdicts_due.pop_front();
                    if (result.overlap !== want.overlap)
                        report_mismatch($sformatf("overlap %b, want %b",
                                                  result.overlap, want.overlap));
                    if (result.separating_axis !== want.separating_axis)
                        report_mismatch($sformatf("separating_axis %0d, want %0d",
                                                  result.separating_axis,
                                                  want.separating_axis));
                end
            end
            if (quiet_cycles >= StallLimit)
            begin
                $display("FAIL obb_face_axis_overlap_test");
                $finish;
            end
        end
    end

    // Drive at the falling edge. Hold the beat until taken, then advance;
    // the idle share rises and falls over four phases of the run.
    always @(negedge clk)
    begin
        int idle_pct;
        int quarter;
        if (rst_n && (taken_last_edge || !start))
        begin
            quarter = (beats_taken * 4) / (total_beats + 1);
            case (quarter)
                1: idle_pct = 45;
                3: idle_pct = 35;
                default: idle_pct = 0;
            endcase
            if (pending_beats.size() != 0 && $urandom_range(99) >= idle_pct)
            begin
                item <= pending_beats.pop_front();
                start <= 1'b1;
            end
            else
                start <= 1'b0;
        end
    end

    initial
    begin
        int r;
        error_count = 0;
        beats_taken = 0;
        quiet_cycles = 0;
        taken_last_edge = 1'b0;
        start = 1'b0;
        item = '0;
        rst_n = 1'b0;

        // Directed: load both boxes completely before any test, so no
        // store entry is read unwritten.
        pending_beats.push_back(make_beat(KIND_CENTRE, 0, 3, 0, 0, 0, '1));
        pending_beats.push_back(make_beat(KIND_CENTRE, 1, 0, 32'h7fff_ffff, 32'h8000_0000,
                                          32'hffff_ffff, '0));
        for (int b = 0; b < 2; b++)
            for (int a = 0; a < 3; a++)
                pending_beats.push_back(make_beat(KIND_AXIS, b, a, a == 0 ? 16384 : 0,
                                                  a == 1 ? 16384 : 0, a == 2 ? 16384 : 0,
                                                  31'h7fff_ffff));
        // Extreme centres against huge extents: overlap.
        pending_beats.push_back(make_beat(KIND_TEST, 1, 3, $urandom, $urandom, $urandom, '1));
        // Tiny extents on both boxes: far centres separate on the first axis.
        for (int b = 0; b < 2; b++)
            for (int a = 0; a < 3; a++)
                pending_beats.push_back(make_beat(KIND_AXIS, b, a, a == 0 ? -16384 : 0,
                                                  a == 1 ? 16384 : 0,
                                                  a == 2 ? 32'hdead_4000 : 0, 31'd0));
        pending_beats.push_back(make_beat(KIND_TEST, 0, 0, 0, 0, 0, '0));
        // Axis slot three and the dropped kind must change nothing.
        pending_beats.push_back(make_beat(KIND_AXIS, 0, AxisSlot3, 0, 0, 0, 31'd1));
        pending_beats.push_back(make_beat(KIND_DROPPED, 1, 2, 1, 1, 1, 31'd5));
        // Non-unit axis with low-half truncation, then coincident centres.
        pending_beats.push_back(make_beat(KIND_AXIS, 1, 2, 32'h1234_7fff, 32'hffff_8000,
                                          32'h0001_0000, 31'd65536));
        pending_beats.push_back(make_beat(KIND_TEST, 0, 0, 0, 0, 0, '0));
        pending_beats.push_back(make_beat(KIND_CENTRE, 0, 0, 32'h7fff_ffff, 32'h8000_0000,
                                          32'hffff_ffff, '0));
        pending_beats.push_back(make_beat(KIND_TEST, 0, 0, 0, 0, 0, '0));

        // Random: mostly well-formed box loads at moderate scale, mixed at random
        // with tests; the rest is full-range noise.
        while (pending_beats.size() < NumRandom + 25)
        begin
            r = $urandom_range(99);
            if (r < 12)
                pending_beats.push_back(noise_beat());
            else if (r < 40)
                pending_beats.push_back(make_beat(KIND_TEST, $urandom_range(1),
                                                  $urandom_range(3), $urandom, $urandom,
                                                  $urandom, 31'($urandom)));
            else if (r < 60)
                pending_beats.push_back(make_beat(KIND_CENTRE, $urandom_range(1),
                                                  $urandom_range(3), rand_centre_comp(),
                                                  rand_centre_comp(), rand_centre_comp(),
                                                  31'($urandom)));
            else
                pending_beats.push_back(make_beat(KIND_AXIS, $urandom_range(1),
                                                  $urandom_range(2), rand_axis_comp(),
                                                  rand_axis_comp(), rand_axis_comp(),
                                                  31'($urandom_range(4 * 65536))));
        end
        total_beats = pending_beats.size();

        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        wait (pending_beats.size() == 0 && !start && verdicts_due.size() == 0);
        repeat (DrainCycles) @(posedge clk);
        if (error_count == 0 && verdicts_due.size() == 0)
            $display("PASS obb_face_axis_overlap_test");
        else
            $display("FAIL obb_face_axis_overlap_test");
        $finish;
    end
endmodule

### filelist.f
src/obb_pkg.sv
src/obb_front.sv
src/obb_back.sv
src/obb_face_axis_overlap_test.sv
test/tb_top.sv
